// ===== sv/complex_square_root_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for complex_square_root
// Shared property forms for the checker.
// ---------------------------------------------------------------------------
`ifndef COMPLEX_SQUARE_ROOT_ASSERT_SVH
`define COMPLEX_SQUARE_ROOT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("complex_square_root: assertion failed");

// next-cycle implication, disabled in reset
`define CSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("complex_square_root: assertion failed");

// plain condition, checked in reset too
`define CSR_ASSERT_ALWAYS(lbl, clk, cond) \
  lbl: assert property (@(posedge clk) (cond)) \
    else $error("complex_square_root: assertion failed");

`endif

// ===== sv/csr_pkg.sv =====
// ---------------------------------------------------------------------------
// csr_pkg
// Widths, angle constants, arc table and inverse gain for the square root.
// ---------------------------------------------------------------------------
package csr_pkg;

  localparam int TBL_LEN   = 40;
  localparam int ANG_W     = 36;
  localparam int XY_W      = 60;
  localparam int K_W       = 34;
  localparam int VEC_SHIFT = 24;
  localparam int ROOT_STG  = 32;

  localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(64'sd2147483648);
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(64'sd1073741824);
  localparam logic signed [K_W-1:0]   SQRT_HALF_Q30 = K_W'(64'sd759250125);
  localparam logic signed [K_W-1:0]   ONE_Q30       = K_W'(64'sd1073741824);

  typedef struct packed {
    logic rz;
    logic iz;
    logic ipos;
    logic ineg;
    logic rneg;
    logic aim_lt;
  } flag_t;

  localparam int FLG_W = $bits(flag_t);

  function automatic logic signed [ANG_W-1:0] arc_step(int i);
    logic signed [ANG_W-1:0] a;
    unique case (i)
      0:  a = 36'sd536870912;
      1:  a = 36'sd316933406;
      2:  a = 36'sd167458907;
      3:  a = 36'sd85004756;
      4:  a = 36'sd42667331;
      5:  a = 36'sd21354465;
      6:  a = 36'sd10679838;
      7:  a = 36'sd5340245;
      8:  a = 36'sd2670163;
      9:  a = 36'sd1335087;
      10: a = 36'sd667544;
      11: a = 36'sd333772;
      12: a = 36'sd166886;
      13: a = 36'sd83443;
      14: a = 36'sd41722;
      15: a = 36'sd20861;
      16: a = 36'sd10430;
      17: a = 36'sd5215;
      18: a = 36'sd2608;
      19: a = 36'sd1304;
      20: a = 36'sd652;
      21: a = 36'sd326;
      22: a = 36'sd163;
      23: a = 36'sd81;
      24: a = 36'sd41;
      25: a = 36'sd20;
      26: a = 36'sd10;
      27: a = 36'sd5;
      28: a = 36'sd3;
      29: a = 36'sd1;
      30: a = 36'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic [63:0] inv_gain_q30(int n);
    logic [63:0] g2;
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] r;
    g2 = 64'd1 << 60;
    for (int i = 0; i < n; i++) begin
      if (2 * i < 64) g2 = g2 + (g2 >> (2 * i));
    end
    rem  = g2;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    if (res == '0) res = 64'd1;
    num = (64'd1 << 60) + (res >> 1);
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= res) begin
        r = r - res;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

// ===== sv/csr_root_cell.sv =====
// ---------------------------------------------------------------------------
// csr_root_cell
// One digit of a 64-bit integer square root, with side data carried along.
// ---------------------------------------------------------------------------
module csr_root_cell #(
  parameter int BIT_POS = 62,
  parameter int SIDE_W  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [63:0]       n_i,
  input  logic [63:0]       res_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [63:0]       n_o,
  output logic [63:0]       res_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              v_q;
  logic [63:0]       n_q, n_d;
  logic [63:0]       res_q, res_d;
  logic [SIDE_W-1:0] side_q;
  logic [63:0]       bitv;
  logic [63:0]       trial;

  assign bitv    = 64'd1 << BIT_POS;
  assign trial   = res_i + bitv;
  assign ready_o = !v_q || ready_i;

  always_comb begin
    if (n_i >= trial) begin
      n_d   = n_i - trial;
      res_d = (res_i >> 1) + bitv;
    end else begin
      n_d   = n_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      n_q    <= n_d;
      res_q  <= res_d;
      side_q <= side_i;
    end
  end

  assign valid_o = v_q;
  assign n_o     = n_q;
  assign res_o   = res_q;
  assign side_o  = side_q;

endmodule

// ===== sv/csr_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// csr_cordic_cell
// One CORDIC micro-rotation, vectoring or rotation mode, side data carried.
// ---------------------------------------------------------------------------
module csr_cordic_cell import csr_pkg::*; #(
  parameter int   W      = 60,
  parameter int   STEP   = 0,
  parameter bit   VECTOR = 1'b1,
  parameter int   SIDE_W = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [W-1:0]     x_i,
  input  logic signed [W-1:0]     y_i,
  input  logic signed [ANG_W-1:0] z_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [W-1:0]     x_o,
  output logic signed [W-1:0]     y_o,
  output logic signed [ANG_W-1:0] z_o,
  output logic [SIDE_W-1:0]       side_o
);

  logic                    v_q;
  logic signed [W-1:0]     x_q, y_q, x_d, y_d, dx, dy;
  logic signed [ANG_W-1:0] z_q, z_d, arc;
  logic [SIDE_W-1:0]       side_q;
  logic                    cw;

  assign arc     = arc_step(STEP);
  assign dx      = y_i >>> STEP;
  assign dy      = x_i >>> STEP;
  assign cw      = VECTOR ? (y_i > 0) : (z_i < 0);
  assign ready_o = !v_q || ready_i;

  always_comb begin
    if (cw) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + arc;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - arc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = v_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

// ===== sv/complex_square_root.sv =====
// ---------------------------------------------------------------------------
// complex_square_root
// Square root of a complex Q15.16 word through a chain of cells.
// ---------------------------------------------------------------------------
// One word enters per cycle while the input is not stalled. A squares
// register and a magnitude register form the squared magnitude, two chains
// of 32 square-root digit cells give the fourth root, a vectoring chain and
// a rotation chain of NSTG cells each (CORDIC_STAGES, capped at TBL_LEN)
// find and halve the angle, and a multiply and a rounding stage scale the
// result. Each cell holds its word while the next cell is full and stalled,
// so stalls at the output back up cell by cell and bubbles close up.
module complex_square_root import csr_pkg::*; #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] in_re_i,
  input  logic [31:0] in_im_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_re_o,
  output logic [31:0] out_im_o
);

  localparam int NSTG   = (CORDIC_STAGES > TBL_LEN) ? TBL_LEN : CORDIC_STAGES;
  localparam int SIDE_A = 64 + FLG_W;
  localparam int SIDE_C = 32 + FLG_W;
  localparam logic signed [K_W-1:0] INV_GAIN = K_W'(inv_gain_q30(NSTG));

  // squares
  logic               s0_v_q, s0_rdy;
  logic signed [63:0] s0_sqr_q, s0_sqi_q, sqr_d, sqi_d;
  logic [31:0]        s0_re_q, s0_im_q;
  flag_t              s0_flg_q, flg_d;
  logic signed [32:0] re33, im33, are, aim;

  assign re33  = 33'(signed'(in_re_i));
  assign im33  = 33'(signed'(in_im_i));
  assign are   = re33[32] ? -re33 : re33;
  assign aim   = im33[32] ? -im33 : im33;
  assign sqr_d = signed'(in_re_i) * signed'(in_re_i);
  assign sqi_d = signed'(in_im_i) * signed'(in_im_i);

  always_comb begin
    flg_d.rz     = (in_re_i == '0);
    flg_d.iz     = (in_im_i == '0);
    flg_d.ipos   = !in_im_i[31] && (in_im_i != '0);
    flg_d.ineg   = in_im_i[31];
    flg_d.rneg   = in_re_i[31];
    flg_d.aim_lt = (aim < are);
  end

  // magnitude squared
  logic        s1_v_q, s1_rdy;
  logic [63:0] s1_mag2_q;
  logic [31:0] s1_re_q, s1_im_q;
  flag_t       s1_flg_q;

  logic              ra_v   [0:ROOT_STG];
  logic              ra_rdy [0:ROOT_STG];
  logic [63:0]       ra_n   [0:ROOT_STG];
  logic [63:0]       ra_res [0:ROOT_STG];
  logic [SIDE_A-1:0] ra_sd  [0:ROOT_STG];
  logic              rb_v   [0:ROOT_STG];
  logic              rb_rdy [0:ROOT_STG];
  logic [63:0]       rb_n   [0:ROOT_STG];
  logic [63:0]       rb_res [0:ROOT_STG];
  logic [SIDE_A-1:0] rb_sd  [0:ROOT_STG];

  assign s0_rdy     = !s0_v_q || s1_rdy;
  assign s1_rdy     = !s1_v_q || ra_rdy[0];
  assign in_stall_o = !s0_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
    end else begin
      if (s0_rdy) s0_v_q <= in_valid_i;
      if (s1_rdy) s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_rdy && in_valid_i) begin
      s0_sqr_q <= sqr_d;
      s0_sqi_q <= sqi_d;
      s0_re_q  <= in_re_i;
      s0_im_q  <= in_im_i;
      s0_flg_q <= flg_d;
    end
    if (s1_rdy && s0_v_q) begin
      s1_mag2_q <= unsigned'(s0_sqr_q) + unsigned'(s0_sqi_q);
      s1_re_q   <= s0_re_q;
      s1_im_q   <= s0_im_q;
      s1_flg_q  <= s0_flg_q;
    end
  end

  assign ra_v[0]   = s1_v_q;
  assign ra_n[0]   = s1_mag2_q;
  assign ra_res[0] = '0;
  assign ra_sd[0]  = {s1_re_q, s1_im_q, s1_flg_q};
  assign ra_rdy[ROOT_STG] = rb_rdy[0];

  assign rb_v[0]   = ra_v[ROOT_STG];
  assign rb_n[0]   = ra_res[ROOT_STG] << FRAC_BITS;
  assign rb_res[0] = '0;
  assign rb_sd[0]  = ra_sd[ROOT_STG];

  for (genvar k = 0; k < ROOT_STG; k++) begin : g_root
    csr_root_cell #(.BIT_POS(62 - 2 * k), .SIDE_W(SIDE_A)) u_ra (
      .clk_i, .rst_ni,
      .valid_i(ra_v[k]), .ready_o(ra_rdy[k]),
      .n_i(ra_n[k]), .res_i(ra_res[k]), .side_i(ra_sd[k]),
      .valid_o(ra_v[k+1]), .ready_i(ra_rdy[k+1]),
      .n_o(ra_n[k+1]), .res_o(ra_res[k+1]), .side_o(ra_sd[k+1])
    );
    csr_root_cell #(.BIT_POS(62 - 2 * k), .SIDE_W(SIDE_A)) u_rb (
      .clk_i, .rst_ni,
      .valid_i(rb_v[k]), .ready_o(rb_rdy[k]),
      .n_i(rb_n[k]), .res_i(rb_res[k]), .side_i(rb_sd[k]),
      .valid_o(rb_v[k+1]), .ready_i(rb_rdy[k+1]),
      .n_o(rb_n[k+1]), .res_o(rb_res[k+1]), .side_o(rb_sd[k+1])
    );
  end

  // vectoring prep
  logic                   s2_v_q, s2_rdy;
  logic signed [XY_W-1:0] s2_x_q, s2_y_q, x_d, y_d, xr, yr;
  logic [SIDE_C-1:0]      s2_sd_q;
  logic [31:0]            b_re, b_im;
  flag_t                  b_flg;

  assign {b_re, b_im, b_flg} = rb_sd[ROOT_STG];
  assign xr  = XY_W'(signed'(b_re));
  assign yr  = XY_W'(signed'(b_im));
  assign x_d = (b_flg.rneg ? -xr : xr) <<< VEC_SHIFT;
  assign y_d = (b_flg.rneg ? -yr : yr) <<< VEC_SHIFT;
  assign rb_rdy[ROOT_STG] = s2_rdy;

  logic                    vc_v   [0:NSTG];
  logic                    vc_rdy [0:NSTG];
  logic signed [XY_W-1:0]  vc_x   [0:NSTG];
  logic signed [XY_W-1:0]  vc_y   [0:NSTG];
  logic signed [ANG_W-1:0] vc_z   [0:NSTG];
  logic [SIDE_C-1:0]       vc_sd  [0:NSTG];

  assign s2_rdy = !s2_v_q || vc_rdy[0];

  // quadrant fix and halving
  logic                    s3_v_q, s3_rdy;
  logic signed [K_W-1:0]   s3_kx_q, s3_ky_q, kx_d, ky_d;
  logic signed [ANG_W-1:0] s3_h_q, h_d, ang, half;
  logic [SIDE_C-1:0]       s3_sd_q;
  flag_t                   v_flg;

  assign v_flg        = vc_sd[NSTG][FLG_W-1:0];
  assign vc_rdy[NSTG] = s3_rdy;

  always_comb begin
    ang = vc_z[NSTG];
    if (v_flg.rneg) begin
      if (v_flg.ipos || v_flg.aim_lt) ang = ang + ANG_PI;
      else ang = ang - ANG_PI;
    end
    half = ang >>> 1;
    if (half > ANG_HALF_PI) begin
      kx_d = '0;
      ky_d = INV_GAIN;
      h_d  = half - ANG_HALF_PI;
    end else begin
      kx_d = INV_GAIN;
      ky_d = '0;
      h_d  = half;
    end
  end

  logic                    rc_v   [0:NSTG];
  logic                    rc_rdy [0:NSTG];
  logic signed [K_W-1:0]   rc_x   [0:NSTG];
  logic signed [K_W-1:0]   rc_y   [0:NSTG];
  logic signed [ANG_W-1:0] rc_z   [0:NSTG];
  logic [SIDE_C-1:0]       rc_sd  [0:NSTG];

  assign s3_rdy = !s3_v_q || rc_rdy[0];

  assign vc_v[0]  = s2_v_q;
  assign vc_x[0]  = s2_x_q;
  assign vc_y[0]  = s2_y_q;
  assign vc_z[0]  = '0;
  assign vc_sd[0] = s2_sd_q;
  assign rc_v[0]  = s3_v_q;
  assign rc_x[0]  = s3_kx_q;
  assign rc_y[0]  = s3_ky_q;
  assign rc_z[0]  = s3_h_q;
  assign rc_sd[0] = s3_sd_q;

  for (genvar k = 0; k < NSTG; k++) begin : g_cordic
    csr_cordic_cell #(.W(XY_W), .STEP(k), .VECTOR(1'b1), .SIDE_W(SIDE_C)) u_vec (
      .clk_i, .rst_ni,
      .valid_i(vc_v[k]), .ready_o(vc_rdy[k]),
      .x_i(vc_x[k]), .y_i(vc_y[k]), .z_i(vc_z[k]), .side_i(vc_sd[k]),
      .valid_o(vc_v[k+1]), .ready_i(vc_rdy[k+1]),
      .x_o(vc_x[k+1]), .y_o(vc_y[k+1]), .z_o(vc_z[k+1]), .side_o(vc_sd[k+1])
    );
    csr_cordic_cell #(.W(K_W), .STEP(k), .VECTOR(1'b0), .SIDE_W(SIDE_C)) u_rot (
      .clk_i, .rst_ni,
      .valid_i(rc_v[k]), .ready_o(rc_rdy[k]),
      .x_i(rc_x[k]), .y_i(rc_y[k]), .z_i(rc_z[k]), .side_i(rc_sd[k]),
      .valid_o(rc_v[k+1]), .ready_i(rc_rdy[k+1]),
      .x_o(rc_x[k+1]), .y_o(rc_y[k+1]), .z_o(rc_z[k+1]), .side_o(rc_sd[k+1])
    );
  end

  // scale by root of modulus
  logic               s4_v_q, s4_rdy;
  logic               s5_rdy;
  logic signed [66:0] s4_pr_q, s4_pi_q;
  logic               s4_neg_q;
  logic signed [K_W-1:0] kxs, kys;
  logic               neg_d;
  logic signed [32:0] zm33;
  flag_t              r_flg;
  logic [31:0]        r_zm;

  assign {r_zm, r_flg} = rc_sd[NSTG];
  assign zm33          = signed'({1'b0, r_zm});
  assign rc_rdy[NSTG]  = s4_rdy;
  assign s4_rdy        = !s4_v_q || s5_rdy;

  always_comb begin
    kxs   = rc_x[NSTG];
    kys   = rc_y[NSTG];
    neg_d = 1'b0;
    if (r_flg.rz) begin
      if (r_flg.iz) begin
        kxs = '0;
        kys = '0;
      end else begin
        kxs   = SQRT_HALF_Q30;
        kys   = SQRT_HALF_Q30;
        neg_d = r_flg.ineg;
      end
    end else if (r_flg.iz) begin
      kxs = r_flg.rneg ? '0 : ONE_Q30;
      kys = r_flg.rneg ? ONE_Q30 : '0;
    end
  end

  // round and drive output
  logic               out_v_q;
  logic [31:0]        out_re_q, out_im_q;
  logic signed [66:0] rnd_re, rnd_im;

  assign rnd_re = (s4_pr_q + 67'sd536870912) >>> 30;
  assign rnd_im = (s4_pi_q + 67'sd536870912) >>> 30;
  assign s5_rdy = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s2_rdy) s2_v_q  <= rb_v[ROOT_STG];
      if (s3_rdy) s3_v_q  <= vc_v[NSTG];
      if (s4_rdy) s4_v_q  <= rc_v[NSTG];
      if (s5_rdy) out_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && rb_v[ROOT_STG]) begin
      s2_x_q  <= x_d;
      s2_y_q  <= y_d;
      s2_sd_q <= {rb_res[ROOT_STG][31:0], b_flg};
    end
    if (s3_rdy && vc_v[NSTG]) begin
      s3_kx_q <= kx_d;
      s3_ky_q <= ky_d;
      s3_h_q  <= h_d;
      s3_sd_q <= vc_sd[NSTG];
    end
    if (s4_rdy && rc_v[NSTG]) begin
      s4_pr_q  <= zm33 * kxs;
      s4_pi_q  <= zm33 * kys;
      s4_neg_q <= neg_d;
    end
    if (s5_rdy && s4_v_q) begin
      out_re_q <= rnd_re[31:0];
      out_im_q <= s4_neg_q ? -rnd_re[31:0] : rnd_im[31:0];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;

endmodule

// ===== sv/csr_checker.sv =====
// ---------------------------------------------------------------------------
// csr_checker
// Port-level checks on complex_square_root, bound to the top level.
// ---------------------------------------------------------------------------
`include "complex_square_root_assert.svh"

module csr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] in_re_i,
  input logic [31:0] in_im_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] out_re_o,
  input logic [31:0] out_im_o
);

  `CSR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `CSR_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_re_o) && $stable(out_im_o))
  `CSR_ASSERT_NEXT(a_in_stable, clk_i, rst_ni, in_valid_i && in_stall_o, in_valid_i && $stable(in_re_i) && $stable(in_im_i))
  `CSR_ASSERT_IMPL(a_stall_blocked, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `CSR_ASSERT_ALWAYS(a_reset_empty, clk_i, rst_ni || !out_valid_o)

endmodule

bind complex_square_root csr_checker u_csr_checker (.*);
